// ===== rtl/core/ufbc_pkg.sv =====
// Package for the union-find bottleneck connect unit.
// Holds field widths, command codes, the controller state type and defaults.
// No dependencies.
package ufbc_pkg;

	localparam int VERT_W           = 10;
	localparam int WEIGHT_W         = 31;
	localparam int CMD_W            = 2;
	localparam int MARK_W           = 11;
	localparam logic [MARK_W-1:0] MARK_CAP = 11'd2047;
	localparam int EDGE_DW          = WEIGHT_W + 2 * VERT_W;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 4096;

	typedef enum logic [CMD_W-1:0] {
		CMD_MARK = 2'd0,
		CMD_EDGE = 2'd1,
		CMD_RUN  = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_E_RD,
		ST_E_EV,
		ST_NEXT,
		ST_F_RD,
		ST_F_EV,
		ST_C_RD,
		ST_C_EV,
		ST_M_RA,
		ST_M_RAEV,
		ST_M_RBEV,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/core/ufbc_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the new data.
// No dependencies.
module ufbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [WIDTH-1:0] byp_data_q;
	logic             byp_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q       <= mem[raddr];
		byp_q      <= we && (waddr == raddr);
		byp_data_q <= wdata;
	end

	assign rdata = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/core/union_find_bottleneck_connect_unit.sv =====
// Union-find bottleneck connect unit: top level with the run sequencer.
// Depends on ufbc_pkg and ufbc_ram.
//
// Usage: drive command and its fields with start high; a request is taken at
// a clock edge where start is high and busy is low. Mark and add-edge requests
// leave busy low, so they may follow back to back.
// A run request raises busy and starts the search: each pass reads the stored
// edges in order, each in read, evaluate and advance steps, handling the edges
// of the current weight through the forest and finding the next larger weight.
// Each parent-memory read of a union-find step has its own read and evaluate
// states. The single result is held on answer_weight and found while done is
// high for a single cycle; done is registered from the finish state, and the
// receiver cannot stall.
// After a run, and after reset, a clearing pass rewrites the parent and mark
// memories, one entry per cycle, with busy high.
module union_find_bottleneck_connect_unit #(
	parameter int MAX_VERTICES = ufbc_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = ufbc_pkg::MAX_EDGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ufbc_pkg::CMD_W-1:0]    command,
	input  logic [ufbc_pkg::VERT_W-1:0]   vertex_a,
	input  logic [ufbc_pkg::VERT_W-1:0]   vertex_b,
	input  logic [ufbc_pkg::WEIGHT_W-1:0] edge_weight,
	output logic                          done,
	output logic [ufbc_pkg::WEIGHT_W-1:0] answer_weight,
	output logic                          found
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int EIW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW    = $clog2(MAX_EDGES + 1);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > ufbc_pkg::MARK_W) ? CNT_W : ufbc_pkg::MARK_W;
	localparam int VW    = ufbc_pkg::VERT_W;
	localparam int WW    = ufbc_pkg::WEIGHT_W;
	localparam int EDW   = ufbc_pkg::EDGE_DW;

	ufbc_pkg::state_t state_q, state_d;

	logic [AW-1:0]                 clr_q;
	logic [EW-1:0]                 edge_total_q;
	logic [ufbc_pkg::MARK_W-1:0]   mark_total_q;
	logic [EW-1:0]                 idx_q;
	logic [WW-1:0]                 t_q, nxt_q, ew_q;
	logic                          have_t_q, nxt_v_q;
	logic [AW-1:0]                 eb_q, cur_q, x_q, root_q, ra_q, rb_q;
	logic                          side_q;
	logic [CNT_W-1:0]              mra_q;
	logic [WW-1:0]                 ans_w_q;
	logic                          ans_f_q, done_q;

	logic                          par_we, mk_we, e_we;
	logic [AW-1:0]                 par_waddr, par_wdata, par_raddr, par_rdata;
	logic [AW-1:0]                 mk_waddr, mk_raddr;
	logic [CNT_W-1:0]              mk_wdata, mk_rdata;
	logic [EIW-1:0]                e_waddr, e_raddr;
	logic [EDW-1:0]                e_wdata, e_rdata;

	logic                          accept, a_ok, b_ok, last_edge, process;
	logic [WW-1:0]                 rd_w;
	logic [AW-1:0]                 rd_a, rd_b;
	logic [CNT_W-1:0]              sum;
	logic                          hit_ra, hit_sum;

	assign accept    = start && (state_q == ufbc_pkg::ST_IDLE);
	assign a_ok      = 32'(vertex_a) < 32'(MAX_VERTICES);
	assign b_ok      = 32'(vertex_b) < 32'(MAX_VERTICES);
	assign last_edge = (idx_q + EW'(1)) == edge_total_q;
	assign rd_w      = e_rdata[EDW-1 -: WW];
	assign rd_a      = AW'(e_rdata[2*VW-1:VW]);
	assign rd_b      = AW'(e_rdata[VW-1:0]);
	assign process   = have_t_q && (rd_w == t_q);
	assign sum       = mra_q + mk_rdata;
	assign hit_ra    = CMP_W'(mk_rdata) == CMP_W'(mark_total_q);
	assign hit_sum   = CMP_W'(sum) == CMP_W'(mark_total_q);

	ufbc_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_parent (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.raddr(par_raddr), .rdata(par_rdata)
	);

	ufbc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_marks (
		.clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
		.raddr(mk_raddr), .rdata(mk_rdata)
	);

	ufbc_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ufbc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAX_VERTICES - 1)) state_d = ufbc_pkg::ST_IDLE;
			end
			ufbc_pkg::ST_IDLE: begin
				if (accept && command == ufbc_pkg::CMD_RUN) begin
					state_d = (edge_total_q == '0) ? ufbc_pkg::ST_FINISH : ufbc_pkg::ST_E_RD;
				end
			end
			ufbc_pkg::ST_E_RD: state_d = ufbc_pkg::ST_E_EV;
			ufbc_pkg::ST_E_EV: state_d = process ? ufbc_pkg::ST_F_RD : ufbc_pkg::ST_NEXT;
			ufbc_pkg::ST_NEXT: begin
				state_d = (last_edge && !nxt_v_q) ? ufbc_pkg::ST_FINISH : ufbc_pkg::ST_E_RD;
			end
			ufbc_pkg::ST_F_RD: state_d = ufbc_pkg::ST_F_EV;
			ufbc_pkg::ST_F_EV: begin
				state_d = (par_rdata == cur_q) ? ufbc_pkg::ST_C_RD : ufbc_pkg::ST_F_RD;
			end
			ufbc_pkg::ST_C_RD: state_d = ufbc_pkg::ST_C_EV;
			ufbc_pkg::ST_C_EV: begin
				if (par_rdata != root_q) state_d = ufbc_pkg::ST_C_RD;
				else if (!side_q) state_d = ufbc_pkg::ST_F_RD;
				else state_d = ufbc_pkg::ST_M_RA;
			end
			ufbc_pkg::ST_M_RA: state_d = ufbc_pkg::ST_M_RAEV;
			ufbc_pkg::ST_M_RAEV: begin
				if (ra_q != rb_q) state_d = ufbc_pkg::ST_M_RBEV;
				else state_d = hit_ra ? ufbc_pkg::ST_FINISH : ufbc_pkg::ST_NEXT;
			end
			ufbc_pkg::ST_M_RBEV: state_d = hit_sum ? ufbc_pkg::ST_FINISH : ufbc_pkg::ST_NEXT;
			ufbc_pkg::ST_FINISH: state_d = ufbc_pkg::ST_CLEAR;
			default: state_d = ufbc_pkg::ST_CLEAR;
		endcase
	end

	// Memory controls.
	always_comb begin
		par_we    = 1'b0;
		par_waddr = x_q;
		par_wdata = root_q;
		par_raddr = cur_q;
		mk_we     = 1'b0;
		mk_waddr  = AW'(vertex_a);
		mk_wdata  = CNT_W'(1);
		mk_raddr  = ra_q;
		e_we      = 1'b0;
		e_waddr   = edge_total_q[EIW-1:0];
		e_wdata   = {edge_weight, vertex_a, vertex_b};
		e_raddr   = idx_q[EIW-1:0];
		case (state_q)
			ufbc_pkg::ST_CLEAR: begin
				par_we    = 1'b1;
				par_waddr = clr_q;
				par_wdata = clr_q;
				mk_we     = 1'b1;
				mk_waddr  = clr_q;
				mk_wdata  = '0;
			end
			ufbc_pkg::ST_IDLE: begin
				mk_we = accept && command == ufbc_pkg::CMD_MARK && a_ok;
				e_we  = accept && command == ufbc_pkg::CMD_EDGE && a_ok && b_ok
					&& (edge_total_q < EW'(MAX_EDGES));
			end
			ufbc_pkg::ST_C_RD: par_raddr = x_q;
			ufbc_pkg::ST_C_EV: par_we = (par_rdata != root_q);
			ufbc_pkg::ST_M_RAEV: mk_raddr = rb_q;
			ufbc_pkg::ST_M_RBEV: begin
				par_we    = 1'b1;
				par_waddr = rb_q;
				par_wdata = ra_q;
				mk_we     = 1'b1;
				mk_waddr  = ra_q;
				mk_wdata  = sum;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ufbc_pkg::ST_CLEAR;
			clr_q        <= '0;
			edge_total_q <= '0;
			mark_total_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ufbc_pkg::ST_FINISH);
			case (state_q)
				ufbc_pkg::ST_CLEAR: clr_q <= (state_d == ufbc_pkg::ST_IDLE) ? '0 : clr_q + AW'(1);
				ufbc_pkg::ST_IDLE: begin
					if (mk_we && mark_total_q != ufbc_pkg::MARK_CAP) begin
						mark_total_q <= mark_total_q + ufbc_pkg::MARK_W'(1);
					end
					if (e_we) edge_total_q <= edge_total_q + EW'(1);
				end
				ufbc_pkg::ST_FINISH: begin
					edge_total_q <= '0;
					mark_total_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Run datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ufbc_pkg::ST_IDLE: begin
				idx_q    <= '0;
				have_t_q <= 1'b0;
				nxt_v_q  <= 1'b0;
				ans_w_q  <= '0;
				ans_f_q  <= 1'b0;
			end
			ufbc_pkg::ST_E_EV: begin
				ew_q   <= rd_w;
				eb_q   <= rd_b;
				cur_q  <= rd_a;
				x_q    <= rd_a;
				side_q <= 1'b0;
				if (!process && (!have_t_q || rd_w > t_q) && (!nxt_v_q || rd_w < nxt_q)) begin
					nxt_q   <= rd_w;
					nxt_v_q <= 1'b1;
				end
			end
			ufbc_pkg::ST_NEXT: begin
				if (last_edge) begin
					idx_q    <= '0;
					t_q      <= nxt_q;
					have_t_q <= 1'b1;
					nxt_v_q  <= 1'b0;
				end else begin
					idx_q <= idx_q + EW'(1);
				end
			end
			ufbc_pkg::ST_F_EV: begin
				if (par_rdata == cur_q) root_q <= cur_q;
				else cur_q <= par_rdata;
			end
			ufbc_pkg::ST_C_EV: begin
				if (par_rdata != root_q) begin
					x_q <= par_rdata;
				end else if (!side_q) begin
					ra_q   <= root_q;
					side_q <= 1'b1;
					cur_q  <= eb_q;
					x_q    <= eb_q;
				end else begin
					rb_q <= root_q;
				end
			end
			ufbc_pkg::ST_M_RAEV: begin
				mra_q <= mk_rdata;
				if (ra_q == rb_q && hit_ra) begin
					ans_w_q <= ew_q;
					ans_f_q <= 1'b1;
				end
			end
			ufbc_pkg::ST_M_RBEV: begin
				if (hit_sum) begin
					ans_w_q <= ew_q;
					ans_f_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != ufbc_pkg::ST_IDLE);
	assign done          = done_q;
	assign answer_weight = ans_w_q;
	assign found         = ans_f_q;

endmodule

// ===== rtl/core/ufbc_checker.sv =====
// Port-level checker for the union-find bottleneck connect unit, with bind.
// Depends on ufbc_pkg and the top level's ports.
module ufbc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [ufbc_pkg::CMD_W-1:0]    command,
	input logic                          done,
	input logic [ufbc_pkg::WEIGHT_W-1:0] answer_weight,
	input logic                          found
);

	// A result only comes while the block is still busy clearing.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> answer_weight == '0) else $error("not-found weight nonzero");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == ufbc_pkg::CMD_RUN |=> busy)
		else $error("run request did not raise busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command != ufbc_pkg::CMD_RUN |=> !busy)
		else $error("load request raised busy");

endmodule

bind union_find_bottleneck_connect_unit ufbc_checker u_ufbc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
	.done(done), .answer_weight(answer_weight), .found(found)
);

// ===== dv/tb_union_find_bottleneck_connect_unit.sv =====
// Testbench for the union-find bottleneck connect unit: directed and random
// mark/edge/run requests checked against a predictor inside a scoreboard class.
// Depends on ufbc_pkg and the RTL of union_find_bottleneck_connect_unit.
`timescale 1ns / 100ps

module tb_union_find_bottleneck_connect_unit;

	localparam int NVERT      = ufbc_pkg::MAX_VERTICES_DEF;
	localparam int NEDGE      = ufbc_pkg::MAX_EDGES_DEF;
	localparam int VW         = ufbc_pkg::VERT_W;
	localparam int WW         = ufbc_pkg::WEIGHT_W;
	localparam int MW         = ufbc_pkg::MARK_W;
	localparam int CW         = ufbc_pkg::CMD_W;
	localparam int STALL_CAP  = 500000;
	localparam int RANDOM_REQ = 1500;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [CW-1:0] command;
	logic [VW-1:0] vertex_a;
	logic [VW-1:0] vertex_b;
	logic [WW-1:0] edge_weight;
	logic          done;
	logic [WW-1:0] answer_weight;
	logic          found;

	int mismatches = 0;
	int runs_seen  = 0;
	int hits_seen  = 0;
	int sent       = 0;
	int stall_cnt  = 0;

	union_find_bottleneck_connect_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .vertex_a(vertex_a), .vertex_b(vertex_b),
		.edge_weight(edge_weight), .done(done), .answer_weight(answer_weight),
		.found(found)
	);

	// Keeps its own copy of the forest and edge list, and the answers owed.
	class bottleneck_board;
		logic [VW-1:0] parent[NVERT];
		logic [MW-1:0] marks[NVERT];
		logic [WW-1:0] ew[NEDGE];
		logic [VW-1:0] ea[NEDGE];
		logic [VW-1:0] eb[NEDGE];
		int            edge_cnt;
		logic [MW-1:0] mark_cnt;
		logic [WW-1:0] owed_weight[$];
		logic          owed_found[$];

		function new();
			clear_forest();
		endfunction

		function void clear_forest();
			for (int i = 0; i < NVERT; i++) begin
				parent[i] = VW'(i);
				marks[i] = '0;
			end
			edge_cnt = 0;
			mark_cnt = '0;
		endfunction

		function int root_of(int x);
			int r;
			int nx;
			r = x;
			while (int'(parent[r]) != r)
				r = int'(parent[r]);
			while (int'(parent[x]) != r) begin
				nx = int'(parent[x]);
				parent[x] = VW'(r);
				x = nx;
			end
			return r;
		endfunction

		function void solve_bottleneck();
			logic [WW-1:0] tw;
			logic [VW-1:0] ta;
			logic [VW-1:0] tb;
			int            j;
			int            ra;
			int            rb;
			logic          hit;
			logic [WW-1:0] ans;
			hit = 1'b0;
			ans = '0;
			// Stable insertion sort keeps load order among equal weights.
			for (int i = 1; i < edge_cnt; i++) begin
				tw = ew[i]; ta = ea[i]; tb = eb[i];
				j = i;
				while (j > 0 && ew[j-1] > tw) begin
					ew[j] = ew[j-1]; ea[j] = ea[j-1]; eb[j] = eb[j-1];
					j--;
				end
				ew[j] = tw; ea[j] = ta; eb[j] = tb;
			end
			for (int i = 0; i < edge_cnt && !hit; i++) begin
				ra = root_of(int'(ea[i]));
				rb = root_of(int'(eb[i]));
				if (ra != rb) begin
					parent[rb] = VW'(ra);
					marks[ra] = marks[ra] + marks[rb];
					rb = ra;
				end
				if (marks[ra] == mark_cnt || marks[rb] == mark_cnt) begin
					hit = 1'b1;
					ans = ew[i];
				end
			end
			owed_weight = {owed_weight, ans};
			owed_found = {owed_found, hit};
			clear_forest();
		endfunction

		function void note_request(ufbc_pkg::cmd_t c, logic [VW-1:0] a, logic [VW-1:0] b,
				logic [WW-1:0] w);
			case (c)
				ufbc_pkg::CMD_MARK: begin
					marks[a] = MW'(1);
					if (mark_cnt != ufbc_pkg::MARK_CAP)
						mark_cnt++;
				end
				ufbc_pkg::CMD_EDGE: begin
					if (edge_cnt < NEDGE) begin
						ew[edge_cnt] = w; ea[edge_cnt] = a; eb[edge_cnt] = b;
						edge_cnt++;
					end
				end
				ufbc_pkg::CMD_RUN: solve_bottleneck();
				default: ;
			endcase
		endfunction

		// Returns 1 on a match; otherwise msg says what went wrong.
		function bit check_result(logic [WW-1:0] w, logic f, output string msg);
			logic [WW-1:0] xw;
			logic          xf;
			msg = "";
			if (owed_found.size() == 0) begin
				msg = $sformatf("result with none owed: weight %0d found %0b", w, f);
				return 0;
			end
			xw = owed_weight.pop_front();
			xf = owed_found.pop_front();
			if (f !== xf)
				msg = $sformatf("found %0b, predicted %0b", f, xf);
			if (w !== xw)
				msg = {msg, $sformatf(" answer_weight %0d, predicted %0d", w, xw)};
			return msg == "";
		endfunction
	endclass

	bottleneck_board board;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	task automatic report(string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send(ufbc_pkg::cmd_t c, logic [VW-1:0] a, logic [VW-1:0] b,
			logic [WW-1:0] w);
		@(negedge clk);
		start <= 1'b1;
		command <= c;
		vertex_a <= a;
		vertex_b <= b;
		edge_weight <= w;
		do @(posedge clk); while (busy);
		board.note_request(c, a, b, w);
		if (c != ufbc_pkg::CMD_NONE)
			sent++;
	endtask

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 60)
			n = 0;
		else if (r < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(20, 200);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			command <= ufbc_pkg::cmd_t'($urandom_range(0, 3));
			vertex_a <= VW'($urandom);
			vertex_b <= VW'($urandom);
			edge_weight <= WW'($urandom);
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Job: a few marks and edges, mostly on a small vertex pool, then a run.
	task automatic random_job(bit noisy);
		logic [VW-1:0] pool[8];
		logic [WW-1:0] w;
		int            nm;
		int            ne;
		bit            narrow;
		nm = $urandom_range(0, 4);
		ne = $urandom_range(0, 14);
		narrow = 1'($urandom_range(0, 1));
		foreach (pool[i])
			pool[i] = VW'($urandom);
		for (int i = 0; i < nm; i++) begin
			send(ufbc_pkg::CMD_MARK, pool[$urandom_range(0, 7)], VW'($urandom),
				WW'($urandom));
			idle_gap();
		end
		for (int i = 0; i < ne; i++) begin
			w = narrow ? WW'($urandom_range(0, 5)) : WW'($urandom);
			if (noisy && $urandom_range(0, 4) == 0)
				send(($urandom_range(0, 1) != 0) ? ufbc_pkg::CMD_NONE : ufbc_pkg::CMD_MARK,
					VW'($urandom), VW'($urandom), WW'($urandom));
			else if ($urandom_range(0, 9) == 0)
				send(ufbc_pkg::CMD_EDGE, VW'($urandom), VW'($urandom), w);
			else
				send(ufbc_pkg::CMD_EDGE, pool[$urandom_range(0, 7)],
					pool[$urandom_range(0, 7)], w);
			idle_gap();
		end
		send(ufbc_pkg::CMD_RUN, VW'($urandom), VW'($urandom), WW'($urandom));
		idle_gap();
	endtask

	always @(posedge clk) begin
		string msg;
		if (done) begin
			runs_seen++;
			if (found)
				hits_seen++;
			if (!board.check_result(answer_weight, found, msg))
				report(msg);
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_CAP) begin
			$display("watchdog expired after %0d idle cycles", stall_cnt);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int wait_cnt;
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		command = ufbc_pkg::CMD_NONE;
		vertex_a = '0;
		vertex_b = '0;
		edge_weight = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Empty store, then no marks with edges: the lightest edge answers.
		send(ufbc_pkg::CMD_RUN, 10'd0, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_EDGE, 10'd7, 10'd8, 31'd40);
		send(ufbc_pkg::CMD_EDGE, 10'd9, 10'd9, 31'd12);
		send(ufbc_pkg::CMD_RUN, 10'd0, 10'd0, 31'd0);
		// Extremes of vertices and weights, with a self-loop ahead of the joining edge.
		send(ufbc_pkg::CMD_MARK, 10'd0, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_MARK, 10'd1023, 10'd1023, 31'h7fffffff);
		send(ufbc_pkg::CMD_EDGE, 10'd5, 10'd5, 31'd0);
		send(ufbc_pkg::CMD_EDGE, 10'd0, 10'd1023, 31'h7fffffff);
		send(ufbc_pkg::CMD_NONE, 10'd1023, 10'd1023, 31'h7fffffff);
		send(ufbc_pkg::CMD_RUN, 10'd1023, 10'd1023, 31'h7fffffff);
		// A repeated mark can never be matched.
		send(ufbc_pkg::CMD_MARK, 10'd3, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_MARK, 10'd3, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_EDGE, 10'd3, 10'd4, 31'd9);
		send(ufbc_pkg::CMD_RUN, 10'd0, 10'd0, 31'd0);
		// Equal weights loaded in both orders.
		send(ufbc_pkg::CMD_MARK, 10'd10, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_MARK, 10'd12, 10'd0, 31'd0);
		send(ufbc_pkg::CMD_EDGE, 10'd11, 10'd12, 31'd6);
		send(ufbc_pkg::CMD_EDGE, 10'd10, 10'd11, 31'd6);
		send(ufbc_pkg::CMD_EDGE, 10'd10, 10'd12, 31'd2);
		send(ufbc_pkg::CMD_EDGE, 10'd20, 10'd21, 31'd6);
		send(ufbc_pkg::CMD_RUN, 10'd0, 10'd0, 31'd0);

		while (sent < RANDOM_REQ) begin
			if ($urandom_range(0, 9) == 0)
				random_job(1'b1);
			else
				random_job(1'b0);
		end

		@(negedge clk);
		start <= 1'b0;
		wait_cnt = 0;
		while (board.owed_found.size() != 0 && wait_cnt < STALL_CAP) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (2 * NVERT + 50) @(posedge clk);

		$display("%0d requests sent, %0d runs checked, %0d answered with an edge weight",
			sent, runs_seen, hits_seen);
		if (mismatches == 0 && board.owed_found.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results never seen", mismatches,
				board.owed_found.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
